### sv/crc8cfr_pkg.sv
// ----------------------------------------------------------------------------
// crc8cfr_pkg
// Shared types, constants and helper functions for the command frame receiver.
// ----------------------------------------------------------------------------
package crc8cfr_pkg;

    localparam int MAX_FRAME_BYTES = 32;
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);

    localparam logic [7:0] LEN_MAX       = 8'(MAX_FRAME_BYTES - 1);
    localparam logic [7:0] SYNC_RESET    = 8'hAA;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    localparam logic [7:0] OP_MOVE     = 8'h01;
    localparam logic [7:0] OP_MPRESS   = 8'h02;
    localparam logic [7:0] OP_MRELEASE = 8'h03;
    localparam logic [7:0] OP_CLICK    = 8'h04;
    localparam logic [7:0] OP_MTIMED   = 8'h05;
    localparam logic [7:0] OP_KPRESS   = 8'h10;
    localparam logic [7:0] OP_KRELEASE = 8'h11;
    localparam logic [7:0] OP_KWRITE   = 8'h12;
    localparam logic [7:0] OP_RELALL   = 8'h13;
    localparam logic [7:0] OP_PRINT    = 8'h14;
    localparam logic [7:0] OP_KTIMED   = 8'h15;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_INVALID = 2'd2,
        ST_PARAM   = 2'd3
    } t_ack_status;

    typedef enum logic [3:0] {
        ACT_MOVE     = 4'd0,
        ACT_MPRESS   = 4'd1,
        ACT_MRELEASE = 4'd2,
        ACT_CLICK    = 4'd3,
        ACT_MTIMED   = 4'd4,
        ACT_KPRESS   = 4'd5,
        ACT_KRELEASE = 4'd6,
        ACT_KWRITE   = 4'd7,
        ACT_RELALL   = 4'd8,
        ACT_PCHAR    = 4'd9,
        ACT_KTIMED   = 4'd10
    } t_action;

    typedef enum logic [2:0] {
        RK_PARAM,
        RK_CRC,
        RK_INVALID,
        RK_OK,
        RK_ACT,
        RK_CHAR
    } t_res_kind;

    typedef enum logic [3:0] {
        S_SYNC,
        S_LEN,
        S_PAY,
        S_OPW,
        S_OP,
        S_AW,
        S_AL,
        S_PW,
        S_PCH,
        S_ACT,
        S_ACK
    } t_state;

    typedef struct packed {
        logic    known;
        t_action act;
        logic [1:0] need;
    } t_op_info;

    typedef struct packed {
        logic      take_len;
        logic      take_pay;
        logic      rd_zero;
        logic      rd_next;
        logic      latch_op;
        logic      arg_shift;
        logic      out_load;
        t_res_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sync;
        logic len_bad;
        logic pay_done;
        logic crc_ok;
        logic op_known;
        logic op_print;
        logic nargs_ok;
        logic len_one;
        logic rd_last;
        logic rd_at_arg3;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic        is_ack;
        logic [1:0]  ack_status;
        logic [3:0]  action;
        logic [7:0]  arg_first;
        logic [7:0]  arg_second;
        logic [7:0]  arg_third;
        logic [15:0] hold_time;
        logic        last_of_run;
    } t_result;

    function automatic t_op_info op_decode(input logic [7:0] op);
        t_op_info info;
        info = '{known: 1'b1, act: ACT_MOVE, need: 2'd0};
        case (op)
            OP_MOVE:     begin info.act = ACT_MOVE;     info.need = 2'd3; end
            OP_MPRESS:   begin info.act = ACT_MPRESS;   info.need = 2'd1; end
            OP_MRELEASE: begin info.act = ACT_MRELEASE; info.need = 2'd1; end
            OP_CLICK:    begin info.act = ACT_CLICK;    info.need = 2'd1; end
            OP_MTIMED:   begin info.act = ACT_MTIMED;   info.need = 2'd3; end
            OP_KPRESS:   begin info.act = ACT_KPRESS;   info.need = 2'd1; end
            OP_KRELEASE: begin info.act = ACT_KRELEASE; info.need = 2'd1; end
            OP_KWRITE:   begin info.act = ACT_KWRITE;   info.need = 2'd1; end
            OP_RELALL:   begin info.act = ACT_RELALL;   info.need = 2'd0; end
            OP_PRINT:    begin info.act = ACT_PCHAR;    info.need = 2'd0; end
            OP_KTIMED:   begin info.act = ACT_KTIMED;   info.need = 2'd3; end
            default: begin
                info.known = 1'b0;
            end
        endcase
        return info;
    endfunction

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/crc8cfr_rx_if.sv
// ----------------------------------------------------------------------------
// crc8cfr_rx_if
// Received byte channel: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface crc8cfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### sv/crc8cfr_res_if.sv
// ----------------------------------------------------------------------------
// crc8cfr_res_if
// Result channel: valid, ready and the fields of one action or acknowledge.
// ----------------------------------------------------------------------------
interface crc8cfr_res_if;
    logic        valid;
    logic        ready;
    logic        is_ack;
    logic [1:0]  ack_status;
    logic [3:0]  action;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [7:0]  arg_third;
    logic [15:0] hold_time;
    logic        last_of_run;

    modport source (
        output valid, output is_ack, output ack_status, output action,
        output arg_first, output arg_second, output arg_third,
        output hold_time, output last_of_run, input ready
    );
    modport sink (
        input valid, input is_ack, input ack_status, input action,
        input arg_first, input arg_second, input arg_third,
        input hold_time, input last_of_run, output ready
    );
endinterface

### sv/crc8cfr_ram.sv
// ----------------------------------------------------------------------------
// crc8cfr_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module crc8cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/crc8cfr_datapath.sv
// ----------------------------------------------------------------------------
// crc8cfr_datapath
// Length, index and crc registers, payload RAM, argument fetch and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module crc8cfr_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [7:0]              i_cfg_wr_data,
    input  logic [7:0]              i_rx_byte,
    input  crc8cfr_pkg::t_dp_cmd    i_cmd,
    output crc8cfr_pkg::t_dp_status o_status,
    crc8cfr_res_if.source           o_res
);
    import crc8cfr_pkg::*;

    logic [7:0]       r_sync_value;
    logic [IDX_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_crc, n_crc;
    logic [IDX_W-1:0] r_rd_addr, n_rd_addr;
    t_action          r_act, n_act;
    logic [7:0]       r_a1, r_a2, r_a3;
    logic [7:0]       n_a1, n_a2, n_a3;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic [7:0]       w_rd_data;
    t_op_info         w_op;

    crc8cfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_pay),
        .i_waddr (r_idx),
        .i_wdata (i_rx_byte),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_data)
    );

    assign w_op = op_decode(w_rd_data);

    always_comb begin
        o_status.is_sync    = (i_rx_byte == r_sync_value);
        o_status.len_bad    = (i_rx_byte == 8'd0) || (i_rx_byte > LEN_MAX);
        o_status.pay_done   = (r_idx == r_len);
        o_status.crc_ok     = (i_rx_byte == r_crc);
        o_status.op_known   = w_op.known;
        o_status.op_print   = (w_op.act == ACT_PCHAR);
        o_status.nargs_ok   = ((r_len - IDX_W'(1)) == IDX_W'(w_op.need));
        o_status.len_one    = (r_len == IDX_W'(1));
        o_status.rd_last    = (r_rd_addr == (r_len - IDX_W'(1)));
        o_status.rd_at_arg3 = (r_rd_addr == IDX_W'(3));
        o_status.out_free   = !r_out_valid || o_res.ready;
    end

    always_comb begin
        n_len     = r_len;
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_rd_addr = r_rd_addr;
        n_act     = r_act;
        n_a1      = r_a1;
        n_a2      = r_a2;
        n_a3      = r_a3;
        if (i_cmd.take_len) begin
            n_len = i_rx_byte[IDX_W-1:0];
            n_idx = '0;
            n_crc = '0;
        end
        if (i_cmd.take_pay) begin
            n_idx = r_idx + IDX_W'(1);
            n_crc = crc8_update(r_crc, i_rx_byte);
        end
        if (i_cmd.rd_zero) begin
            n_rd_addr = '0;
        end else if (i_cmd.rd_next) begin
            n_rd_addr = r_rd_addr + IDX_W'(1);
        end
        if (i_cmd.latch_op) begin
            n_act = w_op.act;
        end
        if (i_cmd.arg_shift) begin
            n_a1 = r_a2;
            n_a2 = r_a3;
            n_a3 = w_rd_data;
        end
    end

    always_comb begin
        n_out       = '0;
        n_out_valid = r_out_valid;
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (i_cmd.out_kind)
            RK_PARAM: begin
                n_out.is_ack      = 1'b1;
                n_out.ack_status  = ST_PARAM;
                n_out.last_of_run = 1'b1;
            end
            RK_CRC: begin
                n_out.is_ack      = 1'b1;
                n_out.ack_status  = ST_CRC;
                n_out.last_of_run = 1'b1;
            end
            RK_INVALID: begin
                n_out.is_ack      = 1'b1;
                n_out.ack_status  = ST_INVALID;
                n_out.last_of_run = 1'b1;
            end
            RK_OK: begin
                n_out.is_ack      = 1'b1;
                n_out.ack_status  = ST_OK;
                n_out.last_of_run = 1'b1;
            end
            RK_CHAR: begin
                n_out.action    = ACT_PCHAR;
                n_out.arg_first = w_rd_data;
            end
            RK_ACT: begin
                n_out.action = r_act;
                case (r_act)
                    ACT_MOVE: begin
                        n_out.arg_first  = r_a1;
                        n_out.arg_second = r_a2;
                        n_out.arg_third  = r_a3;
                    end
                    ACT_MTIMED, ACT_KTIMED: begin
                        n_out.arg_first = r_a1;
                        n_out.hold_time = {r_a2, r_a3};
                    end
                    ACT_RELALL: begin
                        n_out.arg_first = '0;
                    end
                    default: begin
                        n_out.arg_first = r_a1;
                    end
                endcase
            end
            default: begin
                n_out = '0;
            end
        endcase
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
            r_len        <= '0;
            r_idx        <= '0;
            r_crc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sync_value <= i_cfg_wr_data;
            end
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_act     <= n_act;
        r_a1      <= n_a1;
        r_a2      <= n_a2;
        r_a3      <= n_a3;
        r_out     <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.is_ack      = r_out.is_ack;
    assign o_res.ack_status  = r_out.ack_status;
    assign o_res.action      = r_out.action;
    assign o_res.arg_first   = r_out.arg_first;
    assign o_res.arg_second  = r_out.arg_second;
    assign o_res.arg_third   = r_out.arg_third;
    assign o_res.hold_time   = r_out.hold_time;
    assign o_res.last_of_run = r_out.last_of_run;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_res.ready))
        else $error("result loaded over an untaken result");

    a_pay_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_pay |-> (r_idx < r_len))
        else $error("payload byte beyond frame length");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_len_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_len |=> (r_idx == '0) && (r_crc == '0))
        else $error("length byte did not clear index and crc");
endmodule

### sv/crc8cfr_ctrl.sv
// ----------------------------------------------------------------------------
// crc8cfr_ctrl
// Frame state machine: sync, length, payload and crc, then command decode
// and sequencing of the action and acknowledge results.
// ----------------------------------------------------------------------------
module crc8cfr_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  crc8cfr_pkg::t_dp_status i_status,
    output crc8cfr_pkg::t_dp_cmd    o_cmd
);
    import crc8cfr_pkg::*;

    t_state r_state, n_state;
    logic   w_fire;

    assign o_rx_ready = (r_state == S_SYNC)
                     || (((r_state == S_LEN) || (r_state == S_PAY)) && i_status.out_free);
    assign w_fire     = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SYNC: begin
                if (w_fire && i_status.is_sync) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (w_fire) begin
                    n_state = i_status.len_bad ? S_SYNC : S_PAY;
                end
            end
            S_PAY: begin
                if (w_fire && i_status.pay_done) begin
                    n_state = i_status.crc_ok ? S_OPW : S_SYNC;
                end
            end
            S_OPW: begin
                n_state = S_OP;
            end
            S_OP: begin
                if (!i_status.op_known) begin
                    if (i_status.out_free) begin
                        n_state = S_SYNC;
                    end
                end else if (i_status.op_print) begin
                    n_state = i_status.len_one ? S_ACK : S_PW;
                end else if (!i_status.nargs_ok) begin
                    if (i_status.out_free) begin
                        n_state = S_SYNC;
                    end
                end else begin
                    n_state = S_AW;
                end
            end
            S_AW: begin
                n_state = S_AL;
            end
            S_AL: begin
                n_state = i_status.rd_at_arg3 ? S_ACT : S_AW;
            end
            S_PW: begin
                n_state = S_PCH;
            end
            S_PCH: begin
                if (i_status.out_free) begin
                    n_state = i_status.rd_last ? S_ACK : S_PW;
                end
            end
            S_ACT: begin
                if (i_status.out_free) begin
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    n_state = S_SYNC;
                end
            end
            default: begin
                n_state = S_SYNC;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.out_kind = RK_OK;
        case (r_state)
            S_LEN: begin
                if (w_fire) begin
                    o_cmd.take_len = 1'b1;
                    if (i_status.len_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = RK_PARAM;
                    end
                end
            end
            S_PAY: begin
                if (w_fire) begin
                    if (!i_status.pay_done) begin
                        o_cmd.take_pay = 1'b1;
                    end else if (i_status.crc_ok) begin
                        o_cmd.rd_zero = 1'b1;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_kind = RK_CRC;
                    end
                end
            end
            S_OP: begin
                o_cmd.latch_op = 1'b1;
                if (!i_status.op_known) begin
                    o_cmd.out_load = i_status.out_free;
                    o_cmd.out_kind = RK_INVALID;
                end else if (i_status.op_print) begin
                    o_cmd.rd_next = !i_status.len_one;
                end else if (!i_status.nargs_ok) begin
                    o_cmd.out_load = i_status.out_free;
                    o_cmd.out_kind = RK_PARAM;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_AL: begin
                o_cmd.arg_shift = 1'b1;
                o_cmd.rd_next   = !i_status.rd_at_arg3;
            end
            S_PCH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = RK_CHAR;
                    o_cmd.rd_next  = !i_status.rd_last;
                end
            end
            S_ACT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_kind = RK_ACT;
            end
            S_ACK: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_kind = RK_OK;
            end
            default: begin
                o_cmd.out_kind = RK_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC;
        end else begin
            r_state <= n_state;
        end
    end

    a_bad_len_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) && w_fire && i_status.len_bad |=> (r_state == S_SYNC))
        else $error("bad length did not return to sync");

    a_ready_only_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_ready |-> (r_state == S_SYNC) || (r_state == S_LEN) || (r_state == S_PAY))
        else $error("byte accepted during decode");
endmodule

### sv/crc8_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_command_frame_receiver
// Sync / length / payload / crc-8 frame parser with command decoding.
//
//   channel   dir  handshake       payload
//   i_rx      in   valid / ready   rx_byte
//   o_res     out  valid / ready   is_ack, ack_status, action, arg_first,
//                                  arg_second, arg_third, hold_time,
//                                  last_of_run
//   cfg       in   i_cfg_wr_en     i_cfg_wr_data (sync_value)
//
// a new sync, length or payload byte can be taken every clock, but for the stall below
// a good crc byte starts decode: the opcode fetch (S_OPW, S_OP), the argument
// fetch (S_AW, S_AL for each of three argument bytes), then the action and the ack
// print: each text byte is read from the payload RAM read port (S_PW, S_PCH), then the ack
// synchronous reset; sync_value returns to 0xAA
// length, payload and crc bytes stall while the output register holds an
// untaken result; no byte is taken from a good crc byte until the ack loads
// ----------------------------------------------------------------------------
module crc8_command_frame_receiver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data,
    crc8cfr_rx_if.sink    i_rx,
    crc8cfr_res_if.source o_res
);
    import crc8cfr_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    crc8cfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    crc8cfr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_rx.rx_byte),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_res         (o_res)
    );
endmodule
